FILE: hw/rtl/joint_to_conditional_prob_defines.svh
// ----------------------------------------------------------------------------
// Joint-to-conditional assertion macros
// Shared property wrappers for the concurrent checks in the RTL.
// ----------------------------------------------------------------------------
`ifndef JOINT_TO_CONDITIONAL_PROB_DEFINES_SVH
`define JOINT_TO_CONDITIONAL_PROB_DEFINES_SVH

// check an implication on every clock outside reset
`define JCP_ASSERT(name, prop) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("jcp check failed");

// check a condition that must hold on every clock outside reset
`define JCP_ALWAYS(name, cond) \
  name: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("jcp invariant failed");

`endif

FILE: hw/rtl/jcp_pkg.sv
// ----------------------------------------------------------------------------
// Joint-to-conditional package
// Beat types, pipeline stage type, widths, divider step and output functions.
// ----------------------------------------------------------------------------
package jcp_pkg;

  localparam int FRAC_BITS = 15;
  localparam int QW   = 16;
  localparam int GW   = 32;
  localparam int SW   = QW + 1;
  localparam int DW   = 2 * SW;
  localparam int PQ_W = FRAC_BITS + 1;
  localparam int PR_W = SW + 1;
  localparam int GQ_W = QW + FRAC_BITS;
  localparam int GR_W = DW + 1;

  typedef struct packed {
    logic [QW-1:0]        joint_q00;
    logic [QW-1:0]        joint_q01;
    logic [QW-1:0]        joint_q10;
    logic [QW-1:0]        joint_q11;
    logic signed [QW-1:0] grad_p00;
    logic signed [QW-1:0] grad_p01;
    logic signed [QW-1:0] grad_p10;
    logic signed [QW-1:0] grad_p11;
    logic                 last_class;
  } item_t;

  typedef struct packed {
    logic [QW-1:0]        cond_p00;
    logic [QW-1:0]        cond_p01;
    logic [QW-1:0]        cond_p10;
    logic [QW-1:0]        cond_p11;
    logic signed [GW-1:0] grad_q00;
    logic signed [GW-1:0] grad_q01;
    logic signed [GW-1:0] grad_q10;
    logic signed [GW-1:0] grad_q11;
    logic                 last_out;
  } result_t;

  typedef logic [PR_W+PQ_W-1:0] pdiv_t;
  typedef logic [GR_W+GQ_W-1:0] gdiv_t;

  typedef struct packed {
    logic            last;
    logic            z0;
    logic            z1;
    logic            n00;
    logic            n01;
    logic            n10;
    logic            n11;
    logic [SW-1:0]   s0;
    logic [SW-1:0]   s1;
    logic [DW-1:0]   sq0;
    logic [DW-1:0]   sq1;
    pdiv_t           p00;
    pdiv_t           p01;
    pdiv_t           p10;
    pdiv_t           p11;
    gdiv_t           g00;
    gdiv_t           g01;
    gdiv_t           g10;
    gdiv_t           g11;
  } stage_t;

  function automatic pdiv_t prob_step(pdiv_t rl, logic [SW-1:0] den);
    logic [PR_W-1:0] t;
    logic [PQ_W-1:0] low;
    logic            bit_q;
    t     = {rl[PR_W+PQ_W-2:PQ_W], rl[PQ_W-1]};
    low   = rl[PQ_W-1:0];
    bit_q = (t >= {1'b0, den});
    if (bit_q) begin
      t = t - {1'b0, den};
    end
    return {t, low[PQ_W-2:0], bit_q};
  endfunction

  function automatic gdiv_t grad_step(gdiv_t rl, logic [DW-1:0] den);
    logic [GR_W-1:0] t;
    logic [GQ_W-1:0] low;
    logic            bit_q;
    t     = {rl[GR_W+GQ_W-2:GQ_W], rl[GQ_W-1]};
    low   = rl[GQ_W-1:0];
    bit_q = (t >= {1'b0, den});
    if (bit_q) begin
      t = t - {1'b0, den};
    end
    return {t, low[GQ_W-2:0], bit_q};
  endfunction

  function automatic logic [QW-1:0] prob_out(logic zero, pdiv_t rl);
    logic [PQ_W-1:0] q;
    q = rl[PQ_W-1:0];
    if (zero) begin
      return '0;
    end
    if (PQ_W > QW && (q >> QW) != '0) begin
      return '1;
    end
    return q[QW-1:0];
  endfunction

  function automatic logic [GW-1:0] grad_out(logic zero, logic en, logic neg, gdiv_t rl);
    logic [GQ_W-1:0] q;
    logic [GW-1:0]   mag;
    q = rl[GQ_W-1:0];
    if (zero || !en) begin
      return '0;
    end
    if (GQ_W > GW - 1 && (q >> (GW - 1)) != '0) begin
      return neg ? {1'b1, {(GW-1){1'b0}}} : {1'b0, {(GW-1){1'b1}}};
    end
    mag = {1'b0, q[GW-2:0]};
    return neg ? (~mag + 1'b1) : mag;
  endfunction

endpackage

FILE: hw/rtl/joint_to_conditional_prob.sv
// ----------------------------------------------------------------------------
// Joint-to-conditional probability
// Conditional probabilities and joint gradients, one class per beat.
// ----------------------------------------------------------------------------
// Takes one class per cycle unless stalled and passes it through one input
// register, one multiply stage for sums, gradient differences, products and
// squared sums, 31 restoring quotient stages (one quotient bit each, set by
// the 31-bit gradient quotient; the 16-bit probability quotients finish in
// the first 16 of them) and one output register. Each stage holds its beat
// while the next is full and stalled, and a bubble ahead is filled at once.
`include "joint_to_conditional_prob_defines.svh"

module joint_to_conditional_prob (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_data,
  input  logic               item_valid,
  output logic               item_ready,
  input  jcp_pkg::item_t     item,
  output logic               result_valid,
  input  logic               result_ready,
  output jcp_pkg::result_t   result
);

  localparam int NS = jcp_pkg::GQ_W;

  logic                  gradient_enable;
  logic                  iv;
  jcp_pkg::item_t        idata;
  logic                  pv [0:NS];
  jcp_pkg::stage_t       p  [0:NS];
  jcp_pkg::stage_t       pn [0:NS-1];
  jcp_pkg::stage_t       p0_next;
  logic                  padv [0:NS];
  logic                  iadv;
  logic                  oadv;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      gradient_enable <= 1'b1;
    end else if (cfg_valid) begin
      gradient_enable <= cfg_data;
    end
  end

  always_comb begin
    oadv       = !result_valid || result_ready;
    padv[NS]   = !pv[NS] || oadv;
    for (int k = NS - 1; k >= 0; k--) begin
      padv[k] = !pv[k] || padv[k+1];
    end
    iadv       = !iv || padv[0];
    item_ready = iadv;
  end

  always_comb begin
    logic signed [jcp_pkg::SW-1:0] d0;
    logic signed [jcp_pkg::SW-1:0] d1;
    logic [jcp_pkg::QW-1:0]        a0;
    logic [jcp_pkg::QW-1:0]        a1;
    logic [2*jcp_pkg::QW-1:0]      m00;
    logic [2*jcp_pkg::QW-1:0]      m01;
    logic [2*jcp_pkg::QW-1:0]      m10;
    logic [2*jcp_pkg::QW-1:0]      m11;
    d0 = {idata.grad_p00[jcp_pkg::QW-1], idata.grad_p00}
       - {idata.grad_p10[jcp_pkg::QW-1], idata.grad_p10};
    d1 = {idata.grad_p01[jcp_pkg::QW-1], idata.grad_p01}
       - {idata.grad_p11[jcp_pkg::QW-1], idata.grad_p11};
    a0 = d0[jcp_pkg::SW-1] ? jcp_pkg::QW'(-d0) : d0[jcp_pkg::QW-1:0];
    a1 = d1[jcp_pkg::SW-1] ? jcp_pkg::QW'(-d1) : d1[jcp_pkg::QW-1:0];
    m00 = idata.joint_q10 * a0;
    m10 = idata.joint_q00 * a0;
    m01 = idata.joint_q11 * a1;
    m11 = idata.joint_q01 * a1;
    p0_next.last = idata.last_class;
    p0_next.s0   = {1'b0, idata.joint_q00} + {1'b0, idata.joint_q10};
    p0_next.s1   = {1'b0, idata.joint_q01} + {1'b0, idata.joint_q11};
    p0_next.z0   = (p0_next.s0 == '0);
    p0_next.z1   = (p0_next.s1 == '0);
    p0_next.n00  = d0[jcp_pkg::SW-1];
    p0_next.n10  = !d0[jcp_pkg::SW-1] && (d0 != '0);
    p0_next.n01  = d1[jcp_pkg::SW-1];
    p0_next.n11  = !d1[jcp_pkg::SW-1] && (d1 != '0);
    p0_next.sq0  = p0_next.s0 * p0_next.s0;
    p0_next.sq1  = p0_next.s1 * p0_next.s1;
    p0_next.p00  = {{(jcp_pkg::PR_W-jcp_pkg::QW+1){1'b0}}, idata.joint_q00[jcp_pkg::QW-1:1],
                    idata.joint_q00[0], {jcp_pkg::FRAC_BITS{1'b0}}};
    p0_next.p10  = {{(jcp_pkg::PR_W-jcp_pkg::QW+1){1'b0}}, idata.joint_q10[jcp_pkg::QW-1:1],
                    idata.joint_q10[0], {jcp_pkg::FRAC_BITS{1'b0}}};
    p0_next.p01  = {{(jcp_pkg::PR_W-jcp_pkg::QW+1){1'b0}}, idata.joint_q01[jcp_pkg::QW-1:1],
                    idata.joint_q01[0], {jcp_pkg::FRAC_BITS{1'b0}}};
    p0_next.p11  = {{(jcp_pkg::PR_W-jcp_pkg::QW+1){1'b0}}, idata.joint_q11[jcp_pkg::QW-1:1],
                    idata.joint_q11[0], {jcp_pkg::FRAC_BITS{1'b0}}};
    p0_next.g00  = {{(jcp_pkg::GR_W-jcp_pkg::QW){1'b0}}, m00, {jcp_pkg::FRAC_BITS{1'b0}}};
    p0_next.g10  = {{(jcp_pkg::GR_W-jcp_pkg::QW){1'b0}}, m10, {jcp_pkg::FRAC_BITS{1'b0}}};
    p0_next.g01  = {{(jcp_pkg::GR_W-jcp_pkg::QW){1'b0}}, m01, {jcp_pkg::FRAC_BITS{1'b0}}};
    p0_next.g11  = {{(jcp_pkg::GR_W-jcp_pkg::QW){1'b0}}, m11, {jcp_pkg::FRAC_BITS{1'b0}}};
  end

  always_comb begin
    for (int k = 0; k < NS; k++) begin
      pn[k] = p[k];
      if (k < jcp_pkg::PQ_W) begin
        pn[k].p00 = jcp_pkg::prob_step(p[k].p00, p[k].s0);
        pn[k].p10 = jcp_pkg::prob_step(p[k].p10, p[k].s0);
        pn[k].p01 = jcp_pkg::prob_step(p[k].p01, p[k].s1);
        pn[k].p11 = jcp_pkg::prob_step(p[k].p11, p[k].s1);
      end
      pn[k].g00 = jcp_pkg::grad_step(p[k].g00, p[k].sq0);
      pn[k].g10 = jcp_pkg::grad_step(p[k].g10, p[k].sq0);
      pn[k].g01 = jcp_pkg::grad_step(p[k].g01, p[k].sq1);
      pn[k].g11 = jcp_pkg::grad_step(p[k].g11, p[k].sq1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      iv           <= 1'b0;
      result_valid <= 1'b0;
      for (int k = 0; k <= NS; k++) begin
        pv[k] <= 1'b0;
      end
    end else begin
      if (iadv) begin
        iv <= item_valid;
      end
      if (padv[0]) begin
        pv[0] <= iv;
      end
      for (int k = 1; k <= NS; k++) begin
        if (padv[k]) begin
          pv[k] <= pv[k-1];
        end
      end
      if (oadv) begin
        result_valid <= pv[NS];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (iadv) begin
      idata <= item;
    end
    if (padv[0]) begin
      p[0] <= p0_next;
    end
    for (int k = 1; k <= NS; k++) begin
      if (padv[k]) begin
        p[k] <= pn[k-1];
      end
    end
    if (oadv) begin
      result.cond_p00 <= jcp_pkg::prob_out(p[NS].z0, p[NS].p00);
      result.cond_p10 <= jcp_pkg::prob_out(p[NS].z0, p[NS].p10);
      result.cond_p01 <= jcp_pkg::prob_out(p[NS].z1, p[NS].p01);
      result.cond_p11 <= jcp_pkg::prob_out(p[NS].z1, p[NS].p11);
      result.grad_q00 <= jcp_pkg::grad_out(p[NS].z0, gradient_enable, p[NS].n00, p[NS].g00);
      result.grad_q10 <= jcp_pkg::grad_out(p[NS].z0, gradient_enable, p[NS].n10, p[NS].g10);
      result.grad_q01 <= jcp_pkg::grad_out(p[NS].z1, gradient_enable, p[NS].n01, p[NS].g01);
      result.grad_q11 <= jcp_pkg::grad_out(p[NS].z1, gradient_enable, p[NS].n11, p[NS].g11);
      result.last_out <= p[NS].last;
    end
  end

  `JCP_ASSERT(a_grad_off, result_valid && !gradient_enable && $stable(gradient_enable) && $past(oadv) |-> result.grad_q00 == '0 && result.grad_q11 == '0)
  `JCP_ALWAYS(a_prob_sum, !result_valid || ({1'b0, result.cond_p00} + {1'b0, result.cond_p10} <= 17'd32768))
  `JCP_ALWAYS(a_grad_sign, !result_valid || !(result.grad_q00 > 0 && result.grad_q10 > 0))

endmodule

FILE: bench/tb_top.sv
// ----------------------------------------------------------------------------
// Joint-to-conditional probability testbench
// Streams random and corner-case classes through the block, predicts each
// result beat in fixed point and checks it against the result stream.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int PIPE_LAT = 40;

  logic             clk;
  logic             rst;
  logic             cfg_valid;
  logic             cfg_ready;
  logic             cfg_data;
  logic             item_valid;
  logic             item_ready;
  jcp_pkg::item_t   item;
  logic             result_valid;
  logic             result_ready;
  jcp_pkg::result_t result;

  jcp_pkg::item_t   pending_items[$];
  jcp_pkg::result_t expected_results[$];
  logic             grad_en;
  int               mismatches;
  int               send_gap;
  int               recv_gap;
  bit               hold_off_req;
  int               hold_off_cnt;

  joint_to_conditional_prob dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .item_valid(item_valid), .item_ready(item_ready), .item(item),
    .result_valid(result_valid), .result_ready(result_ready), .result(result)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [15:0] cond_ratio(logic [15:0] q, logic [16:0] s);
    logic [63:0] r;
    if (s == 0) begin
      return '0;
    end
    r = ({48'd0, q} << jcp_pkg::FRAC_BITS) / s;
    return (r > 64'hFFFF) ? 16'hFFFF : r[15:0];
  endfunction

  function automatic logic [31:0] joint_grad(logic [15:0] q, longint d, logic [16:0] s);
    logic [63:0] mag;
    logic [63:0] den;
    if (s == 0 || q == 0 || d == 0) begin
      return '0;
    end
    mag = q * ((d < 0) ? -d : d);
    mag = mag << jcp_pkg::FRAC_BITS;
    den = s * s;
    mag = mag / den;
    if (d < 0) begin
      return (mag >= 64'h8000_0000) ? 32'h8000_0000 : (32'd0 - mag[31:0]);
    end
    return (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
  endfunction

  function automatic jcp_pkg::result_t predict_class(jcp_pkg::item_t it, logic en);
    jcp_pkg::result_t r;
    logic [16:0] s0;
    logic [16:0] s1;
    longint g00, g01, g10, g11;
    s0  = it.joint_q00 + it.joint_q10;
    s1  = it.joint_q01 + it.joint_q11;
    g00 = it.grad_p00;
    g01 = it.grad_p01;
    g10 = it.grad_p10;
    g11 = it.grad_p11;
    r.cond_p00 = cond_ratio(it.joint_q00, s0);
    r.cond_p01 = cond_ratio(it.joint_q01, s1);
    r.cond_p10 = cond_ratio(it.joint_q10, s0);
    r.cond_p11 = cond_ratio(it.joint_q11, s1);
    r.grad_q00 = en ? joint_grad(it.joint_q10, g00 - g10, s0) : '0;
    r.grad_q01 = en ? joint_grad(it.joint_q11, g01 - g11, s1) : '0;
    r.grad_q10 = en ? joint_grad(it.joint_q00, g10 - g00, s0) : '0;
    r.grad_q11 = en ? joint_grad(it.joint_q01, g11 - g01, s1) : '0;
    r.last_out = it.last_class;
    return r;
  endfunction

  function automatic logic [15:0] rand_q();
    case ($urandom_range(0, 9))
      0: return 16'd0;
      1: return 16'd32768;
      2: return 16'hFFFF;
      3: return 16'($urandom_range(0, 15));
      4, 5: return 16'($urandom);
      default: return 16'($urandom_range(0, 32768));
    endcase
  endfunction

  function automatic logic [15:0] rand_g();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic jcp_pkg::item_t rand_class();
    jcp_pkg::item_t it;
    it.joint_q00  = rand_q();
    it.joint_q01  = rand_q();
    it.joint_q10  = rand_q();
    it.joint_q11  = rand_q();
    it.grad_p00   = rand_g();
    it.grad_p01   = rand_g();
    it.grad_p10   = rand_g();
    it.grad_p11   = rand_g();
    it.last_class = 1'($urandom_range(0, 1));
    return it;
  endfunction

  function automatic jcp_pkg::item_t make_class(int a, int b, int c, int d,
                                                int e, int f, int g, int h, bit l);
    jcp_pkg::item_t it;
    it.joint_q00 = 16'(a); it.joint_q01 = 16'(b);
    it.joint_q10 = 16'(c); it.joint_q11 = 16'(d);
    it.grad_p00  = 16'(e); it.grad_p01  = 16'(f);
    it.grad_p10  = 16'(g); it.grad_p11  = 16'(h);
    it.last_class = l;
    return it;
  endfunction

  task automatic write_grad_enable(logic v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    grad_en = v;
  endtask

  task automatic drain();
    while (pending_items.size() != 0 || item_valid || expected_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (PIPE_LAT) @(posedge clk);
  endtask

  task automatic load_directed();
    pending_items.push_back(make_class(0, 0, 0, 0, 100, -5, 7, 3, 1));
    pending_items.push_back(make_class(32768, 32768, 0, 0, 32767, 32767, -32768, -32768, 0));
    pending_items.push_back(make_class(0, 0, 32768, 32768, -32768, -32768, 32767, 32767, 1));
    pending_items.push_back(make_class(1, 1, 1, 1, 32767, -32768, -32768, 32767, 0));
    pending_items.push_back(make_class(1, 2, 65535, 65535, 32767, 0, -32768, 0, 1));
    pending_items.push_back(make_class(65535, 65535, 1, 1, -32768, 32767, 32767, -32768, 0));
    pending_items.push_back(make_class(65535, 65535, 65535, 65535, 1, 2, 3, 4, 1));
    pending_items.push_back(make_class(16384, 8192, 16384, 24576, 500, -500, -500, 500, 0));
    pending_items.push_back(make_class(5, 0, 0, 9, 32767, 32767, -32768, -32768, 1));
    pending_items.push_back(make_class(12345, 54321, 23456, 6543, -1, 1, 1, -1, 0));
    pending_items.push_back(make_class(3, 3, 32765, 32765, 1234, 1234, 1234, 1234, 1));
  endtask

  // sender
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      send_gap   <= 0;
    end else if (!item_valid || item_ready) begin
      if (item_valid && item_ready) begin
        expected_results.push_back(predict_class(item, grad_en));
      end
      if (send_gap > 0) begin
        send_gap   <= send_gap - 1;
        item_valid <= 1'b0;
      end else if (pending_items.size() != 0) begin
        item       <= pending_items.pop_front();
        item_valid <= 1'b1;
        send_gap   <= ($urandom_range(0, 3) != 0) ? 0 :
                      ($urandom_range(0, 9) == 0 ? $urandom_range(5, 40)
                                                  : $urandom_range(1, 3));
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  // receiver
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
      recv_gap     <= 0;
      hold_off_cnt <= 0;
    end else begin
      if (result_valid && result_ready) begin
        if (expected_results.size() == 0) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10) $display("unexpected result beat %h", result);
        end else begin
          jcp_pkg::result_t exp_r;
          exp_r = expected_results.pop_front();
          if (exp_r.cond_p00 !== result.cond_p00 || exp_r.cond_p01 !== result.cond_p01 ||
              exp_r.cond_p10 !== result.cond_p10 || exp_r.cond_p11 !== result.cond_p11 ||
              exp_r.grad_q00 !== result.grad_q00 || exp_r.grad_q01 !== result.grad_q01 ||
              exp_r.grad_q10 !== result.grad_q10 || exp_r.grad_q11 !== result.grad_q11 ||
              exp_r.last_out !== result.last_out) begin
            mismatches = mismatches + 1;
            if (mismatches <= 10) begin
              $display("mismatch exp %h", exp_r);
              $display("         got %h", result);
            end
          end
        end
      end
      if (hold_off_req && hold_off_cnt == 0) begin
        hold_off_cnt <= 200;
        result_ready <= 1'b0;
      end else if (hold_off_cnt > 1) begin
        hold_off_cnt <= hold_off_cnt - 1;
        result_ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap     <= recv_gap - 1;
        result_ready <= 1'b0;
      end else begin
        result_ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) begin
          recv_gap <= ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40)
                                                  : $urandom_range(1, 3);
        end
      end
    end
  end

  initial begin
    rst          = 1'b1;
    cfg_valid    = 1'b0;
    cfg_data     = 1'b0;
    grad_en      = 1'b1;
    mismatches   = 0;
    hold_off_req = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    write_grad_enable(1'b1);
    load_directed();
    drain();
    write_grad_enable(1'b0);
    load_directed();
    for (int i = 0; i < 120; i++) pending_items.push_back(rand_class());
    drain();
    write_grad_enable(1'b1);
    for (int i = 0; i < 400; i++) pending_items.push_back(rand_class());
    hold_off_req = 1'b1;
    wait (hold_off_cnt != 0);
    hold_off_req = 1'b0;
    drain();
    write_grad_enable(1'b0);
    for (int i = 0; i < 80; i++) pending_items.push_back(rand_class());
    drain();
    write_grad_enable(1'b1);
    for (int i = 0; i < 330; i++) pending_items.push_back(rand_class());
    drain();
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/jcp_pkg.sv
hw/rtl/joint_to_conditional_prob.sv
bench/tb_top.sv
